>>> design/rmst_pkg.sv
// Package for the range maximum segment tree: sizes, field widths and
// the fill value of the node memory. No dependencies.
`default_nettype none

package rmst_pkg;

  localparam int unsigned MAX_LEAVES = 1024;
  localparam int unsigned NODE_COUNT = 2 * MAX_LEAVES;
  localparam int unsigned NODE_W     = $clog2(NODE_COUNT);  // node address bits
  localparam int unsigned BOUND_W    = NODE_W + 1;          // query bounds reach NODE_COUNT
  localparam int unsigned CNT_W      = 11;                  // leaf_count register
  localparam int unsigned POS_W      = 10;
  localparam int unsigned END_W      = 11;
  localparam int unsigned DATA_W     = 32;

  localparam int unsigned IN_FIELD_W = POS_W + END_W + DATA_W;
  localparam int unsigned IN_TDATA_W = ((IN_FIELD_W + 7) / 8) * 8;

  localparam logic signed [DATA_W-1:0] MOST_NEG = {1'b1, {(DATA_W-1){1'b0}}};

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

endpackage

`default_nettype wire

>>> design/range_max_segment_tree_top.sv
// Range maximum segment tree: point writes and half-open range max queries
// over a 2048-word node memory with a registered read. Uses rmst_pkg.
// Flow: a write stores the leaf, then writes each parent up to the root;
//   a query checks the left and then the right boundary of each tree level
//   it climbs. One item is in work at a time; the next item is taken in the
//   cycle after the result loads, and the single read port of the node
//   memory sets the pace of a query.
// Reset: leaf_count returns to 1024 and a clearing pass fills all 2048 nodes
//   with the most negative value, one per cycle; no item is taken meanwhile.
`default_nettype none

module range_max_segment_tree_top (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // Input items
  input  wire logic                             s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  // [9:0] position, [20:10] range_end, [52:21] new_value, [55:53] zero
  input  wire logic [rmst_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,
  // [0] mode
  input  wire logic [0:0]                       s_axis_tuser_i,
  // Result items
  output logic                                  m_axis_tvalid_o,
  input  wire logic                             m_axis_tready_i,
  // [31:0] max_value
  output logic [rmst_pkg::DATA_W-1:0]           m_axis_tdata_o,
  // [0] index_error
  output logic [0:0]                            m_axis_tuser_o,
  // leaf_count register
  input  wire logic                             cfg_we_i,
  input  wire logic [rmst_pkg::CNT_W-1:0]       cfg_wdata_i
);

  localparam int unsigned NW = rmst_pkg::NODE_W;
  localparam int unsigned BW = rmst_pkg::BOUND_W;
  localparam int unsigned DW = rmst_pkg::DATA_W;
  localparam int unsigned PW = rmst_pkg::POS_W;
  localparam int unsigned EW = rmst_pkg::END_W;
  localparam int unsigned CW = rmst_pkg::CNT_W;

  typedef enum logic [7:0] {
    ST_CLEAR  = 8'b0000_0001,
    ST_IDLE   = 8'b0000_0010,
    ST_W_LEAF = 8'b0000_0100,
    ST_W_UP   = 8'b0000_1000,
    ST_Q_LO   = 8'b0001_0000,
    ST_Q_HI   = 8'b0010_0000,
    ST_DONE   = 8'b0100_0000
  } state_e;

  // Unpack the input item
  logic                 in_mode;
  logic [PW-1:0]        in_pos;
  logic [EW-1:0]        in_end;
  logic signed [DW-1:0] in_value;

  assign in_mode  = s_axis_tuser_i[0];
  assign in_pos   = s_axis_tdata_i[PW-1:0];
  assign in_end   = s_axis_tdata_i[PW+EW-1:PW];
  assign in_value = $signed(s_axis_tdata_i[PW+EW+DW-1:PW+EW]);

  // Control and working registers
  state_e               state_q, state_d;
  logic [CW-1:0]        leaf_count_q;
  logic [NW-1:0]        clr_cnt_q, clr_cnt_d;
  logic [NW-1:0]        k_q, k_d;          // write path: current node
  logic signed [DW-1:0] cur_q, cur_d;      // write path: value of node k
  logic [BW-1:0]        lo_q, lo_d;        // query bounds, node space
  logic [BW-1:0]        hi_q, hi_d;
  logic signed [DW-1:0] best_q, best_d;    // running result
  logic                 err_q, err_d;
  logic                 rd_vld_q, rd_vld_d; // query read lands next cycle

  // Output register
  logic                 out_vld_q;
  logic signed [DW-1:0] out_data_q;
  logic                 out_err_q;

  // Node memory ports
  logic                 mem_we;
  logic [NW-1:0]        mem_waddr;
  logic signed [DW-1:0] mem_wdata;
  logic                 mem_re;
  logic [NW-1:0]        mem_raddr;
  logic signed [DW-1:0] mem_rdata_q;
  logic signed [DW-1:0] tree_mem_q [rmst_pkg::NODE_COUNT];

  // Leaves in use: zero counts as one, anything past the tree size is clamped
  logic [CW-1:0] n_eff;
  always_comb begin
    if (leaf_count_q == '0) begin
      n_eff = CW'(1);
    end else if (leaf_count_q > CW'(rmst_pkg::MAX_LEAVES)) begin
      n_eff = CW'(rmst_pkg::MAX_LEAVES);
    end else begin
      n_eff = leaf_count_q;
    end
  end

  logic                 in_acc;
  logic                 out_load;
  logic [NW-1:0]        parent;
  logic signed [DW-1:0] par_max;
  logic [BW-1:0]        hi_dec;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign out_load        = (state_q == ST_DONE) && (!out_vld_q || m_axis_tready_i);
  assign parent          = k_q >> 1;
  assign par_max         = (mem_rdata_q > cur_q) ? mem_rdata_q : cur_q;
  assign hi_dec          = hi_q - BW'(1);

  always_comb begin
    state_d   = state_q;
    clr_cnt_d = clr_cnt_q;
    k_d       = k_q;
    cur_d     = cur_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    best_d    = best_q;
    err_d     = err_q;
    rd_vld_d  = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = k_q;
    mem_wdata = cur_q;
    mem_re    = 1'b0;
    mem_raddr = k_q ^ NW'(1);

    // Fold in the node read by the previous query step
    if (rd_vld_q && (mem_rdata_q > best_q)) begin
      best_d = mem_rdata_q;
    end

    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_q;
        mem_wdata = rmst_pkg::MOST_NEG;
        clr_cnt_d = clr_cnt_q + NW'(1);
        if (clr_cnt_q == '1) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_acc) begin
          if (in_mode == rmst_pkg::MODE_WRITE) begin
            best_d = '0;
            k_d    = NW'(in_pos) + NW'(n_eff);
            cur_d  = in_value;
            if (CW'(in_pos) >= n_eff) begin
              err_d   = 1'b1;
              state_d = ST_DONE;
            end else begin
              err_d   = 1'b0;
              state_d = ST_W_LEAF;
            end
          end else begin
            best_d = rmst_pkg::MOST_NEG;
            lo_d   = BW'(in_pos) + BW'(n_eff);
            hi_d   = BW'(in_end) + BW'(n_eff);
            if ((CW'(in_pos) > n_eff) || (in_end > n_eff)) begin
              err_d   = 1'b1;
              state_d = ST_DONE;
            end else begin
              err_d   = 1'b0;
              state_d = ST_Q_LO;
            end
          end
        end
      end

      // Store the leaf and, unless it is the root, fetch its sibling
      ST_W_LEAF: begin
        mem_we    = 1'b1;
        mem_waddr = k_q;
        mem_wdata = cur_q;
        if (k_q > NW'(1)) begin
          mem_re    = 1'b1;
          mem_raddr = k_q ^ NW'(1);
          state_d   = ST_W_UP;
        end else begin
          state_d = ST_DONE;
        end
      end

      // Write the parent and, below the root, fetch the parent's sibling in the same cycle
      ST_W_UP: begin
        mem_we    = 1'b1;
        mem_waddr = parent;
        mem_wdata = par_max;
        cur_d     = par_max;
        k_d       = parent;
        if (parent > NW'(1)) begin
          mem_re    = 1'b1;
          mem_raddr = parent ^ NW'(1);
        end else begin
          state_d = ST_DONE;
        end
      end

      // Left boundary of one level
      ST_Q_LO: begin
        if (lo_q >= hi_q) begin
          state_d = ST_DONE;
        end else begin
          if (lo_q[0]) begin
            mem_re    = 1'b1;
            mem_raddr = lo_q[NW-1:0];
            rd_vld_d  = 1'b1;
            lo_d      = lo_q + BW'(1);
          end
          state_d = ST_Q_HI;
        end
      end

      // Right boundary, then climb one level
      ST_Q_HI: begin
        lo_d = lo_q >> 1;
        hi_d = hi_q >> 1;
        if (hi_q[0]) begin
          mem_re    = 1'b1;
          mem_raddr = hi_dec[NW-1:0];
          rd_vld_d  = 1'b1;
          hi_d      = hi_dec >> 1;
        end
        state_d = ST_Q_LO;
      end

      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      clr_cnt_q    <= '0;
      leaf_count_q <= CW'(rmst_pkg::MAX_LEAVES);
      rd_vld_q     <= 1'b0;
      out_vld_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      clr_cnt_q <= clr_cnt_d;
      rd_vld_q <= rd_vld_d;
      if (cfg_we_i) begin
        leaf_count_q <= cfg_wdata_i;
      end
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Working payload
  always_ff @(posedge clk_i) begin
    k_q    <= k_d;
    cur_q  <= cur_d;
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    best_q <= best_d;
    err_q  <= err_d;
    if (out_load) begin
      out_data_q <= best_q;
      out_err_q  <= err_q;
    end
  end

  // Node memory, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      tree_mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= tree_mem_q[mem_raddr];
    end
  end

  assign m_axis_tvalid_o   = out_vld_q;
  assign m_axis_tdata_o    = out_data_q;
  assign m_axis_tuser_o[0] = out_err_q;

  // A read never targets the node being written in the same cycle
  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
    else $error("node read and write collide");

  // The update walk only runs below the root
  a_walk_below_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_W_UP) |-> (k_q > NW'(1)))
    else $error("update walk passed the root");

  // Query read data only arrives inside the query loop
  a_query_read_in_loop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> ((state_q == ST_Q_LO) || (state_q == ST_Q_HI)))
    else $error("query read data outside query loop");

endmodule

`default_nettype wire
